/* rtl/pn2d_pkg.sv */
package pn2d_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 16;
  localparam int NOISE_W             = 18;
  localparam int COORD_W             = 32;
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd131072;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage

/* rtl/perlin_noise_2d_unit.sv */
// An accepted request moves through the stage registers in order to the output register.
// Throughput: one request per cycle; the pipeline advances on every cycle in
// which the output register is empty or being taken.
// Reset: rst_n (synchronous, active low) clears every stage valid bit; data
// registers are not reset.
module perlin_noise_2d_unit #(
  parameter int COORD_FRAC_BITS = pn2d_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = pn2d_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pn2d_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pn2d_pkg::COORD_W-1:0] in_coord_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pn2d_pkg::NOISE_W-1:0] out_noise_value
);
  import pn2d_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  // working width: fractions, gradients and products fit comfortably
  localparam int W  = F + 5;
  localparam int PW = 2 * W;
  localparam int NS = 9;
  localparam logic signed [W-1:0] ONE  = W'(1) <<< F;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);
  localparam logic signed [W-1:0] K6   = W'(6);
  localparam logic signed [W-1:0] K15  = W'(15) <<< F;
  localparam logic signed [W-1:0] K10  = W'(10) <<< F;
  localparam int SH = OUT_FRAC_BITS - F;
  localparam int CW = W + OUT_FRAC_BITS + 1;
  localparam logic signed [CW-1:0] CRND = (SH < 0) ? (CW'(1) <<< (SH < 0 ? -SH-1 : 0)) : '0;

  // round half up of p / 2^F; arithmetic shift is floor
  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + HALF) >>> F;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] grad(input logic [7:0] h,
                                              input logic signed [W-1:0] dx,
                                              input logic signed [W-1:0] dy);
    logic signed [W-1:0] gx, gy;
    gx = h[0] ? -dx : dx;
    gy = h[1] ? -dy : dy;
    return gx + gy;
  endfunction

  logic [NS-1:0] vld_r;
  logic          adv;
  assign adv      = !vld_r[NS-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // stage 1: split coordinates, first ROM lookups
  logic signed [W-1:0] fx1_r, fy1_r;
  logic [7:0] iy1_r, pa1_r, pb1_r;
  logic [7:0] ix_w;
  assign ix_w = in_coord_x[F+7:F];

  // stage 2: hashes, t*t, t*(6t-15)+10
  logic signed [W-1:0] fx2_r, fy2_r, txx2_r, tyx2_r, pxx2_r, pyx2_r;
  logic [7:0] h00_2_r, h10_2_r, h01_2_r, h11_2_r;
  // stage 3: t^3, p, corner gradients
  logic signed [W-1:0] t3x3_r, t3y3_r, px3_r, py3_r;
  logic signed [W-1:0] g00_3_r, g10_3_r, g01_3_r, g11_3_r;
  // stage 4: fade
  logic signed [W-1:0] u4_r, v4_r, g00_4_r, g10_4_r, g01_4_r, g11_4_r;
  // stage 5: x products
  logic signed [PW-1:0] m0_5_r, m1_5_r;
  logic signed [W-1:0] v5_r, g00_5_r, g01_5_r;
  // stage 6: x lerps
  logic signed [W-1:0] a6_r, b6_r, v6_r;
  // stage 7: y product
  logic signed [PW-1:0] m7_r;
  logic signed [W-1:0] a7_r;
  // stage 8: y lerp
  logic signed [W-1:0] r8_r;
  logic signed [NOISE_W-1:0] res9_r;

  logic signed [W-1:0] fu_c, fv_c;
  logic signed [PW-1:0] fu_p, fv_p;
  logic signed [CW-1:0] cv_c;
  logic signed [NOISE_W-1:0] sat_c;

  always_comb begin
    fu_p = PW'(t3x3_r) * PW'(px3_r);
    fv_p = PW'(t3y3_r) * PW'(py3_r);
    fu_c = rnd(fu_p);
    fv_c = rnd(fv_p);
    if (fu_c < 0) fu_c = '0;
    if (fu_c > ONE) fu_c = ONE;
    if (fv_c < 0) fv_c = '0;
    if (fv_c > ONE) fv_c = ONE;
    if (SH >= 0) begin
      cv_c = CW'(r8_r) <<< (SH >= 0 ? SH : 0);
    end else begin
      cv_c = (CW'(r8_r) + CRND) >>> (SH < 0 ? -SH : 0);
    end
    if (cv_c > CW'(NOISE_MAX)) sat_c = NOISE_MAX;
    else if (cv_c < CW'(NOISE_MIN)) sat_c = NOISE_MIN;
    else sat_c = cv_c[NOISE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx1_r <= W'({1'b0, in_coord_x[F-1:0]});
      fy1_r <= W'({1'b0, in_coord_y[F-1:0]});
      iy1_r <= in_coord_y[F+7:F];
      pa1_r <= PERM[ix_w];
      pb1_r <= PERM[8'(ix_w + 8'd1)];

      fx2_r   <= fx1_r;
      fy2_r   <= fy1_r;
      txx2_r  <= rnd(PW'(fx1_r) * PW'(fx1_r));
      tyx2_r  <= rnd(PW'(fy1_r) * PW'(fy1_r));
      pxx2_r  <= rnd(PW'(fx1_r) * PW'(K6 * fx1_r - K15)) + K10;
      pyx2_r  <= rnd(PW'(fy1_r) * PW'(K6 * fy1_r - K15)) + K10;
      h00_2_r <= PERM[8'(pa1_r + iy1_r)];
      h10_2_r <= PERM[8'(pb1_r + iy1_r)];
      h01_2_r <= PERM[8'(pa1_r + iy1_r + 8'd1)];
      h11_2_r <= PERM[8'(pb1_r + iy1_r + 8'd1)];

      t3x3_r  <= rnd(PW'(txx2_r) * PW'(fx2_r));
      t3y3_r  <= rnd(PW'(tyx2_r) * PW'(fy2_r));
      px3_r   <= pxx2_r;
      py3_r   <= pyx2_r;
      g00_3_r <= grad(h00_2_r, fx2_r, fy2_r);
      g10_3_r <= grad(h10_2_r, fx2_r - ONE, fy2_r);
      g01_3_r <= grad(h01_2_r, fx2_r, fy2_r - ONE);
      g11_3_r <= grad(h11_2_r, fx2_r - ONE, fy2_r - ONE);

      u4_r    <= fu_c;
      v4_r    <= fv_c;
      g00_4_r <= g00_3_r;
      g10_4_r <= g10_3_r;
      g01_4_r <= g01_3_r;
      g11_4_r <= g11_3_r;

      m0_5_r  <= PW'(g10_4_r - g00_4_r) * PW'(u4_r);
      m1_5_r  <= PW'(g11_4_r - g01_4_r) * PW'(u4_r);
      v5_r    <= v4_r;
      g00_5_r <= g00_4_r;
      g01_5_r <= g01_4_r;

      a6_r <= g00_5_r + rnd(m0_5_r);
      b6_r <= g01_5_r + rnd(m1_5_r);
      v6_r <= v5_r;

      m7_r <= PW'(b6_r - a6_r) * PW'(v6_r);
      a7_r <= a6_r;

      r8_r <= a7_r + rnd(m7_r);

      res9_r <= sat_c;
    end
  end

  assign out_noise_value = res9_r;

endmodule
